/* src/csa_pkg.sv */
// csa_pkg: shared types and constants for the call argument slot allocator
// depends on nothing; used by csa_alloc and call_argument_slot_allocator_unit
package csa_pkg;

	localparam int unsigned NUM_REGS   = 8;
	localparam int unsigned SLOT_BYTES = 8;
	localparam int unsigned PAIR_BYTES = 16;
	localparam int unsigned MAX_ALIGN  = 16;
	localparam int unsigned HFA_MAX    = 4;

	typedef enum logic [1:0] {
		KIND_GP    = 2'd0,
		KIND_VEC   = 2'd1,
		KIND_STACK = 2'd2
	} kind_t;

	typedef struct packed {
		logic        first_arg;
		logic        last_arg;
		logic        is_array;
		logic        struct_arg;
		logic        float_arg;
		logic        is_single;
		logic [15:0] byte_size;
		logic [4:0]  byte_align;
		logic [2:0]  hfa_members;
	} arg_t;

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  reg_idx;
		logic        by_reference;
		logic        overflow;
	} place_t;

endpackage

/* src/csa_alloc.sv */
// csa_alloc: combinational placement of one argument from the current counters
// returns the placement and the next register and stack counters
// depends on csa_pkg
module csa_alloc #(
	parameter int unsigned STACK_BITS = 20
) (
	input  csa_pkg::arg_t          arg,
	input  logic [3:0]             gp_q,
	input  logic [3:0]             vec_q,
	input  logic [STACK_BITS-1:0]  sb_q,
	output csa_pkg::place_t        place,
	output logic [STACK_BITS-1:0]  slot_offset,
	output logic [3:0]             gp_next,
	output logic [3:0]             vec_next,
	output logic [STACK_BITS-1:0]  sb_next
);

	localparam int unsigned EW = STACK_BITS + 18;
	localparam logic [EW-1:0] STACK_MAX = EW'((64'd1 << STACK_BITS) - 64'd1);
	localparam logic [3:0]  REGS4  = 4'(csa_pkg::NUM_REGS);
	localparam logic [4:0]  REGS5  = 5'(csa_pkg::NUM_REGS);
	localparam logic [16:0] SLOT17 = 17'(csa_pkg::SLOT_BYTES);
	localparam logic [16:0] PAIR17 = 17'(csa_pkg::PAIR_BYTES);
	localparam logic [4:0]  ALIGN_MAX = 5'(csa_pkg::MAX_ALIGN);
	localparam logic [2:0]  HFA_MAX3 = 3'(csa_pkg::HFA_MAX);

	function automatic logic [4:0] fix_align(input logic [4:0] a);
		if (a <= 5'd1) return 5'd1;
		else if (a <= 5'd2) return 5'd2;
		else if (a <= 5'd4) return 5'd4;
		else if (a <= 5'd8) return 5'd8;
		else return 5'd16;
	endfunction

	function automatic logic [16:0] round8(input logic [16:0] v);
		logic [17:0] s;
		s = {1'b0, v} + 18'd7;
		return {s[16:3], 3'b000};
	endfunction

	logic [3:0]    gp, vec, g8, gp_inc1;
	logic [STACK_BITS-1:0] sb;
	logic          arr, st, fl;
	logic [2:0]    hfa;
	logic [16:0]   size, sz, st_size;
	logic [4:0]    al;
	logic          use_stack;
	logic [EW-1:0] a_m1, sum, off, off_c, stack_end, end_c;
	logic          ovf_off, ovf_end;
	logic [16:0]   gp_room;
	logic [4:0]    vec_hfa;
	logic [16:0]   words;

	always_comb begin
		gp  = arg.first_arg ? 4'd0 : gp_q;
		vec = arg.first_arg ? 4'd0 : vec_q;
		sb  = arg.first_arg ? '0 : sb_q;

		arr = arg.is_array;
		st  = arg.struct_arg & ~arr;
		fl  = arg.float_arg & ~st & ~arr;
		hfa = (st && arg.hfa_members >= 3'd1 && arg.hfa_members <= HFA_MAX3) ?
			arg.hfa_members : 3'd0;
		size = {1'b0, arg.byte_size};
		al   = fix_align(arg.byte_align);
		if (arr) begin
			size = SLOT17;
			al   = 5'd8;
		end

		vec_hfa = {1'b0, vec} + {2'b00, hfa};
		gp_inc1 = gp + 4'd1;
		g8      = (al == ALIGN_MAX) ? {gp_inc1[3:1], 1'b0} : gp;
		gp_room = {10'd0, REGS4 - g8, 3'b000};
		sz      = st ? round8(size) : size;
		words   = (sz + 17'd7) >> 3;

		place.kind         = csa_pkg::KIND_STACK;
		place.reg_idx      = 3'd0;
		place.by_reference = 1'b0;
		use_stack = 1'b0;
		st_size   = size;
		gp_next   = gp;
		vec_next  = vec;

		if (hfa == 3'd0 && (size > PAIR17 || arr)) begin
			place.by_reference = 1'b1;
			if (gp < REGS4) begin
				place.kind    = csa_pkg::KIND_GP;
				place.reg_idx = gp[2:0];
				gp_next       = gp + 4'd1;
			end else begin
				use_stack = 1'b1;
				al        = 5'd8;
				st_size   = SLOT17;
			end
		end else if (fl && vec < REGS4) begin
			place.kind    = csa_pkg::KIND_VEC;
			place.reg_idx = vec[2:0];
			vec_next      = vec + 4'd1;
		end else if (hfa != 3'd0 && vec_hfa <= REGS5) begin
			place.kind    = csa_pkg::KIND_VEC;
			place.reg_idx = vec[2:0];
			vec_next      = vec_hfa[3:0];
		end else if (hfa != 3'd0 || fl) begin
			use_stack = 1'b1;
			if (hfa != 3'd0) begin
				vec_next = REGS4;
				st_size  = round8(size);
			end else if (arg.is_single || size < SLOT17) begin
				st_size = SLOT17;
			end
		end else if (!st && sz <= SLOT17 && gp < REGS4) begin
			place.kind    = csa_pkg::KIND_GP;
			place.reg_idx = gp[2:0];
			gp_next       = gp + 4'd1;
		end else if (!st && sz == PAIR17 && g8 < REGS4 - 4'd1) begin
			place.kind    = csa_pkg::KIND_GP;
			place.reg_idx = g8[2:0];
			gp_next       = g8 + 4'd2;
		end else if (st && g8 < REGS4 && sz <= gp_room) begin
			place.kind    = csa_pkg::KIND_GP;
			place.reg_idx = g8[2:0];
			gp_next       = g8 + words[3:0];
		end else begin
			gp_next   = REGS4;
			use_stack = 1'b1;
			st_size   = (!st && sz < SLOT17) ? SLOT17 : sz;
		end

		// stack slot aligned to the larger of 8 and the argument alignment
		a_m1      = (al == ALIGN_MAX) ? EW'(15) : EW'(7);
		sum       = EW'(sb) + a_m1;
		off       = sum & ~a_m1;
		ovf_off   = off > STACK_MAX;
		off_c     = ovf_off ? STACK_MAX : off;
		stack_end = off_c + EW'(st_size);
		ovf_end   = stack_end > STACK_MAX;
		end_c     = ovf_end ? STACK_MAX : stack_end;

		place.overflow = use_stack & (ovf_off | ovf_end);
		slot_offset    = use_stack ? off_c[STACK_BITS-1:0] : '0;
		sb_next        = use_stack ? end_c[STACK_BITS-1:0] : sb;
	end

endmodule

/* src/call_argument_slot_allocator_unit.sv */
// call_argument_slot_allocator_unit: top level of the argument slot allocator
// input register, placement logic (csa_alloc), result register and counters
// depends on csa_pkg and csa_alloc
//
// usage: one call argument is a transfer on the in channel (in_valid/in_ready),
// one placement comes back per argument as a transfer on the out channel
// (out_valid/out_ready), in order. first_arg clears the general register,
// vector register and stack counters before its own argument is placed.
// timing: an argument is registered in the input register and its placement
// in the result register, from which it can transfer; the input register and
// the result register hold one argument each.
// throughput: one argument per cycle while out_ready is high, set by the
// single pass through csa_alloc between the input register and the result
// register, which also updates the three counters.
// stall: while out_ready is low the result stays, the input register keeps
// one more argument and in_ready drops once both are full.
// reset: arst_n clears both valid flags and all counters asynchronously.
module call_argument_slot_allocator_unit #(
	parameter int unsigned STACK_BITS = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  first_arg,
	input  logic                  last_arg,
	input  logic                  is_array,
	input  logic                  struct_arg,
	input  logic                  float_arg,
	input  logic                  is_single,
	input  logic [15:0]           byte_size,
	input  logic [4:0]            byte_align,
	input  logic [2:0]            hfa_members,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            place_kind,
	output logic [2:0]            reg_num,
	output logic [STACK_BITS-1:0] slot_offset,
	output logic                  by_reference,
	output logic [STACK_BITS-1:0] stack_total,
	output logic                  is_last,
	output logic                  overflow
);

	csa_pkg::arg_t   arg_s1;
	logic            valid_s1;
	csa_pkg::place_t place_s2;
	logic [STACK_BITS-1:0] offset_s2, total_s2;
	logic            last_s2;
	logic            valid_s2;

	logic [3:0]            gp_q, vec_q;
	logic [STACK_BITS-1:0] sb_q;

	csa_pkg::place_t       place;
	logic [STACK_BITS-1:0] offset_c;
	logic [3:0]            gp_n, vec_n;
	logic [STACK_BITS-1:0] sb_n;
	logic                  adv;

	assign adv      = valid_s1 & (~valid_s2 | out_ready);
	assign in_ready = ~valid_s1 | adv;

	csa_alloc #(.STACK_BITS(STACK_BITS)) u_alloc (
		.arg          (arg_s1),
		.gp_q         (gp_q),
		.vec_q        (vec_q),
		.sb_q         (sb_q),
		.place        (place),
		.slot_offset  (offset_c),
		.gp_next      (gp_n),
		.vec_next     (vec_n),
		.sb_next      (sb_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			gp_q     <= 4'd0;
			vec_q    <= 4'd0;
			sb_q     <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
				gp_q     <= gp_n;
				vec_q    <= vec_n;
				sb_q     <= sb_n;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			arg_s1.first_arg   <= first_arg;
			arg_s1.last_arg    <= last_arg;
			arg_s1.is_array    <= is_array;
			arg_s1.struct_arg  <= struct_arg;
			arg_s1.float_arg   <= float_arg;
			arg_s1.is_single   <= is_single;
			arg_s1.byte_size   <= byte_size;
			arg_s1.byte_align  <= byte_align;
			arg_s1.hfa_members <= hfa_members;
		end
		if (adv) begin
			place_s2  <= place;
			offset_s2 <= offset_c;
			total_s2  <= sb_n;
			last_s2   <= arg_s1.last_arg;
		end
	end

	assign out_valid    = valid_s2;
	assign place_kind   = place_s2.kind;
	assign reg_num      = place_s2.reg_idx;
	assign slot_offset  = offset_s2;
	assign by_reference = place_s2.by_reference;
	assign stack_total  = total_s2;
	assign is_last      = last_s2;
	assign overflow     = place_s2.overflow;

	a_counter_range: assert property (@(posedge clk) disable iff (!arst_n)
		gp_q <= 4'(csa_pkg::NUM_REGS) && vec_q <= 4'(csa_pkg::NUM_REGS))
		else $error("register counter beyond register count");

	a_in_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("input transfer lost");

	a_stack_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && place_kind == csa_pkg::KIND_STACK |-> reg_num == 3'd0)
		else $error("stack placement carries a register number");

	a_reg_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && place_kind != csa_pkg::KIND_STACK |-> slot_offset == '0 && !overflow)
		else $error("register placement carries a stack offset");

endmodule
